>>> src/rgbhsv_pkg.sv
// Package for the RGB to HSV converter: default sizes and the code that
// names which component is the largest. No dependencies.
package rgbhsv_pkg;

  localparam int unsigned RGBHSV_COMPONENT_BITS = 8;
  localparam int unsigned RGBHSV_FRACTION_BITS  = 16;

  // Which component holds the maximum; red wins ties, then green.
  typedef enum logic [1:0] {
    MAX_RED   = 2'd0,
    MAX_GREEN = 2'd1,
    MAX_BLUE  = 2'd2
  } max_sel_t;

endpackage

>>> src/rgbhsv_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone module; used twice by rgb_to_hsv_converter.
module rgbhsv_div #(
  parameter int unsigned DW = 11,
  parameter int unsigned QW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_in,
  input  logic [QW-1:0] low_in,
  input  logic [DW-1:0] dv_in,
  output logic [QW-1:0] quot
);

  // The partial remainder stays below the divisor if it enters below it;
  // the divisor travels with the item, so every stage works on its own request.
  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] q_r   [QW];
  logic [DW-1:0] dv_r  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_i;
    logic [QW-1:0] low_i;
    logic [QW-1:0] q_i;
    logic [DW-1:0] dv_i;
    logic [DW:0]   t;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_i = rem_in;
      assign low_i = low_in;
      assign q_i   = '0;
      assign dv_i  = dv_in;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign low_i = low_r[k-1];
      assign q_i   = q_r[k-1];
      assign dv_i  = dv_r[k-1];
    end

    assign t  = {rem_i, low_i[QW-1]};
    assign ge = (t >= {1'b0, dv_i});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DW'(t - {1'b0, dv_i}) : t[DW-1:0];
        low_r[k] <= {low_i[QW-2:0], 1'b0};
        q_r[k]   <= {q_i[QW-2:0], ge};
        dv_r[k]  <= dv_i;
      end
    end
  end

  assign quot = q_r[QW-1];

endmodule

>>> src/rgb_to_hsv_converter.sv
// RGB to HSV converter, FRACTION_BITS + 2 register stages deep (compare, numerator, then one
// stage per quotient bit in two parallel restoring dividers): out_valid rises when the accepted
// pixel reaches the last stage. Throughput is one pixel per clock; in_ready drops only while
// the one-entry output skid holds a result that the sink refused. Reset (rst_n low, synchronous)
// clears all valid bits and the skid entry; payload registers are not reset. Depends on
// rgbhsv_pkg and rgbhsv_div.
module rgb_to_hsv_converter
  import rgbhsv_pkg::*;
#(
  parameter int unsigned COMPONENT_BITS = RGBHSV_COMPONENT_BITS,
  parameter int unsigned FRACTION_BITS  = RGBHSV_FRACTION_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COMPONENT_BITS-1:0] in_red,
  input  logic [COMPONENT_BITS-1:0] in_green,
  input  logic [COMPONENT_BITS-1:0] in_blue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [FRACTION_BITS-1:0]  out_hue,
  output logic [FRACTION_BITS-1:0]  out_saturation,
  output logic [COMPONENT_BITS-1:0] out_brightness
);

  localparam int unsigned C  = COMPONENT_BITS;
  localparam int unsigned F  = FRACTION_BITS;
  // Hue divisor is 6d, which needs three bits more than a component.
  localparam int unsigned HW = C + 3;
  // Stage 0 compares, stage 1 builds the numerators, then F divider stages.
  localparam int unsigned S  = F + 2;

  // The whole pipeline moves together whenever the skid entry is free. The
  // last stage's request is then either taken at the port or parked in the
  // skid, so nothing is lost when the pipeline advances over it.
  logic         en;
  logic [S-1:0] valid_r;
  logic         skid_valid_r;
  logic         skid_valid_nxt;

  assign en       = !skid_valid_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[S-2:0], in_valid};
    end
  end

  // Stage 0: find the largest and smallest component and which one wins.
  logic [C-1:0] r_a_r, g_a_r, b_a_r, mx_a_r, mn_a_r;
  max_sel_t     sel_a_r;
  logic [C-1:0] mx_nxt, mn_nxt;
  max_sel_t     sel_nxt;

  always_comb begin
    if (in_red >= in_green && in_red >= in_blue) begin
      sel_nxt = MAX_RED;
      mx_nxt  = in_red;
    end else if (in_green >= in_blue) begin
      sel_nxt = MAX_GREEN;
      mx_nxt  = in_green;
    end else begin
      sel_nxt = MAX_BLUE;
      mx_nxt  = in_blue;
    end
    mn_nxt = in_red;
    if (in_green < mn_nxt) mn_nxt = in_green;
    if (in_blue < mn_nxt)  mn_nxt = in_blue;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_a_r   <= in_red;
      g_a_r   <= in_green;
      b_a_r   <= in_blue;
      mx_a_r  <= mx_nxt;
      mn_a_r  <= mn_nxt;
      sel_a_r <= sel_nxt;
    end
  end

  // Stage 1: chroma d, the hue numerator (in [0, 6d) unless d is zero) and the
  // saturation dividend (2^F - 1) * d, split into the part that seeds the
  // remainder and the low bits that the divider shifts in.
  logic [C-1:0]   d;
  logic [HW-1:0]  d2, d4, d6, num_nxt;
  logic [C+F-1:0] sat_dvd;

  assign d       = mx_a_r - mn_a_r;
  assign d2      = HW'(d) << 1;
  assign d4      = HW'(d) << 2;
  assign d6      = d2 + d4;
  assign sat_dvd = {d, {F{1'b0}}} - (C + F)'(d);

  // The results of the subtractions are non-negative and fit in HW bits,
  // so plain modular arithmetic at that width is exact.
  always_comb begin
    case (sel_a_r)
      MAX_RED: begin
        if (g_a_r >= b_a_r) begin
          num_nxt = HW'(g_a_r) - HW'(b_a_r);
        end else begin
          num_nxt = d6 - (HW'(b_a_r) - HW'(g_a_r));
        end
      end
      MAX_GREEN: num_nxt = d2 + HW'(b_a_r) - HW'(r_a_r);
      MAX_BLUE:  num_nxt = d4 + HW'(r_a_r) - HW'(g_a_r);
      default:   num_nxt = '0;
    endcase
  end

  logic [HW-1:0] hnum_b_r, hdiv_b_r;
  logic [C-1:0]  srem_b_r, sdiv_b_r, mx_b_r;
  logic [F-1:0]  slow_b_r;
  logic          hz_b_r, sz_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hnum_b_r <= num_nxt;
      hdiv_b_r <= d6;
      srem_b_r <= sat_dvd[C+F-1:F];
      slow_b_r <= sat_dvd[F-1:0];
      sdiv_b_r <= mx_a_r;
      mx_b_r   <= mx_a_r;
      // A grey pixel has no hue, a black one no saturation either; the
      // dividers see a zero divisor then, so their quotients are masked.
      hz_b_r   <= (d == '0);
      sz_b_r   <= (mx_a_r == '0);
    end
  end

  // Divider stages, with the value and the two mask flags riding alongside.
  logic [F-1:0] hue_q, sat_q;

  rgbhsv_div #(
    .DW(HW),
    .QW(F)
  ) u_hue_div (
    .clk   (clk),
    .en    (en),
    .rem_in(hnum_b_r),
    .low_in({F{1'b0}}),
    .dv_in (hdiv_b_r),
    .quot  (hue_q)
  );

  rgbhsv_div #(
    .DW(C),
    .QW(F)
  ) u_sat_div (
    .clk   (clk),
    .en    (en),
    .rem_in(srem_b_r),
    .low_in(slow_b_r),
    .dv_in (sdiv_b_r),
    .quot  (sat_q)
  );

  logic [C-1:0] mx_p_r [F];
  logic [F-1:0] hz_p_r;
  logic [F-1:0] sz_p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mx_p_r[0] <= mx_b_r;
      for (int i = 1; i < F; i++) begin
        mx_p_r[i] <= mx_p_r[i-1];
      end
      hz_p_r <= {hz_p_r[F-2:0], hz_b_r};
      sz_p_r <= {sz_p_r[F-2:0], sz_b_r};
    end
  end

  logic [F-1:0] last_hue, last_sat;
  logic [C-1:0] last_bright;
  logic         last_valid;

  assign last_valid  = valid_r[S-1];
  assign last_hue    = hz_p_r[F-1] ? '0 : hue_q;
  assign last_sat    = sz_p_r[F-1] ? '0 : sat_q;
  assign last_bright = mx_p_r[F-1];

  // Output skid: holds the oldest result when the sink stalls, so the
  // pipeline can still advance over the stalled result before it freezes.
  logic [F-1:0] skid_hue_r, skid_sat_r;
  logic [C-1:0] skid_bright_r;

  always_comb begin
    if (skid_valid_r) begin
      skid_valid_nxt = !out_ready;
    end else begin
      skid_valid_nxt = last_valid && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
    end else begin
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid_r) begin
      skid_hue_r    <= last_hue;
      skid_sat_r    <= last_sat;
      skid_bright_r <= last_bright;
    end
  end

  assign out_valid      = skid_valid_r || last_valid;
  assign out_hue        = skid_valid_r ? skid_hue_r    : last_hue;
  assign out_saturation = skid_valid_r ? skid_sat_r    : last_sat;
  assign out_brightness = skid_valid_r ? skid_bright_r : last_bright;

  // Reset empties every stage and the skid entry.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (valid_r == '0) && !skid_valid_r)
    else $error("pipeline not empty after reset");

  // A black pixel must leave with zero hue and zero saturation.
  a_black_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_brightness == '0) |-> (out_hue == '0 && out_saturation == '0))
    else $error("black pixel produced nonzero hue or saturation");

  // While the skid is full and the sink refuses, the pipeline stands still and the skid stays full.
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ready) |=> $stable(valid_r) && skid_valid_r)
    else $error("pipeline moved while the output skid was full");

endmodule
